[rtl/assert_macros.svh]
// assert_macros.svh: assertion shorthands shared by the halftoner RTL.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/edh_pkg.sv]
// edh_pkg: types, constants and arithmetic helpers of the error diffusion halftoner.
// No dependencies; used by edh_core, error_diffusion_halftone and the testbench.
package edh_pkg;

  localparam int PIX_W     = 8;
  localparam int DIM_W     = 11;
  localparam int ROW_W     = 10;
  localparam int ERR_W     = 10;
  localparam int RAW_W     = 11;
  localparam int WIDE_W    = 13;
  localparam int CFG_IDX_W = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

  // Reset values and limits
  localparam logic [PIX_W-1:0] THRESHOLD_RST = 8'd128;
  localparam logic [DIM_W-1:0] WIDTH_RST     = 11'd1024;
  localparam logic [DIM_W-1:0] HEIGHT_RST    = 11'd1024;
  localparam logic [DIM_W-1:0] HEIGHT_LIMIT  = 11'd1024;
  localparam logic [DIM_W-1:0] DIM_MIN       = 11'd2;

  localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;
  localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;

  // Diffusion weights in sixteenths
  localparam logic [2:0] K_RIGHT      = 3'd7;
  localparam logic [2:0] K_DOWN_LEFT  = 3'd3;
  localparam logic [2:0] K_DOWN       = 3'd5;
  localparam logic [2:0] K_DOWN_RIGHT = 3'd1;

  typedef logic signed [ERR_W-1:0] err_val_t;

  localparam err_val_t ERR_MAX  = 10'sd511;
  localparam err_val_t ERR_MIN  = -10'sd512;
  localparam err_val_t ERR_ZERO = 10'sd0;

  // Error state carried from one pixel to the next
  typedef struct packed {
    err_val_t right_carry;
    err_val_t pend_prev;
    err_val_t pend_cur;
  } err_state_t;

  // Position flags of a pixel in the raster
  typedef struct packed {
    logic last_col;
    logic last_row;
  } pos_t;

  // Saturate to 10-bit signed
  function automatic err_val_t sat10(input logic signed [WIDE_W-1:0] v);
    err_val_t r;
    if (v > WIDE_W'(ERR_MAX)) r = ERR_MAX;
    else if (v < WIDE_W'(ERR_MIN)) r = ERR_MIN;
    else r = ERR_W'(v);
    return r;
  endfunction

  // k/16 of e, truncated toward zero
  function automatic err_val_t share(input logic signed [RAW_W-1:0] e, input logic [2:0] k);
    logic [RAW_W-1:0]  mag;
    logic [WIDE_W-1:0] prod;
    err_val_t          q;
    mag  = e[RAW_W-1] ? RAW_W'(-e) : RAW_W'(e);
    prod = WIDE_W'(mag) * WIDE_W'(k);
    q    = $signed(ERR_W'(prod >> 4));
    return e[RAW_W-1] ? -q : q;
  endfunction

endpackage

[rtl/edh_mem.sv]
// edh_mem: single-write, single-read row error memory with registered read data.
// No dependencies; instantiated by error_diffusion_halftone.
module edh_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/edh_core.sv]
// edh_core: per-pixel threshold and error split of the halftoner.
// Uses edh_pkg; instantiated by error_diffusion_halftone.
module edh_core (
  input  logic [edh_pkg::PIX_W-1:0] pixel,
  input  edh_pkg::err_val_t         row_err,
  input  edh_pkg::err_state_t       err_in,
  input  logic [edh_pkg::PIX_W-1:0] threshold,
  input  edh_pkg::pos_t             pos,
  output logic                      white,
  output edh_pkg::err_state_t       err_next,
  output edh_pkg::err_val_t         left_data,
  output edh_pkg::err_val_t         below_data
);

  logic signed [edh_pkg::WIDE_W-1:0] sum;
  edh_pkg::err_val_t                 value;
  logic signed [edh_pkg::RAW_W-1:0]  err;
  edh_pkg::err_val_t                 sh_right, sh_dl, sh_down, sh_dr;

  // Working value and threshold
  always_comb begin
    sum   = $signed({5'b00000, pixel}) + edh_pkg::WIDE_W'(err_in.right_carry)
            + edh_pkg::WIDE_W'(row_err);
    value = edh_pkg::sat10(sum);
    white = value > $signed({2'b00, threshold});
    err   = white ? edh_pkg::RAW_W'(value) - 11'sd255 : edh_pkg::RAW_W'(value);
  end

  // Error shares
  always_comb begin
    sh_right   = edh_pkg::share(err, edh_pkg::K_RIGHT);
    sh_dl      = edh_pkg::share(err, edh_pkg::K_DOWN_LEFT);
    sh_down    = edh_pkg::share(err, edh_pkg::K_DOWN);
    sh_dr      = edh_pkg::share(err, edh_pkg::K_DOWN_RIGHT);
    left_data  = edh_pkg::sat10(edh_pkg::WIDE_W'(err_in.pend_prev) + edh_pkg::WIDE_W'(sh_dl));
    below_data = edh_pkg::sat10(edh_pkg::WIDE_W'(err_in.pend_cur) + edh_pkg::WIDE_W'(sh_down));
  end

  // Carried state for the next pixel
  always_comb begin
    err_next.right_carry = pos.last_col ? edh_pkg::ERR_ZERO
                                        : edh_pkg::sat10(edh_pkg::WIDE_W'(sh_right));
    if (pos.last_row || pos.last_col) begin
      err_next.pend_prev = edh_pkg::ERR_ZERO;
      err_next.pend_cur  = edh_pkg::ERR_ZERO;
    end else begin
      err_next.pend_prev = below_data;
      err_next.pend_cur  = sh_dr;
    end
  end

endmodule

[rtl/error_diffusion_halftone.sv]
// Floyd-Steinberg error diffusion halftoner, top level.
// Uses edh_pkg, edh_mem, edh_core and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid / in_stall / pixel_in) takes 8-bit grey pixels in
//   raster order; a transfer happens on an edge with valid high and stall low.
//   Output channel (out_valid / out_stall / pixel_out, row_end, image_end)
//   gives one binary pixel (0 or 255) per input, with row_end on the last
//   pixel of each row and image_end on the last pixel of the image.
//   out_valid rises as the result moves from the compute stage register to the
//   output register. Throughput is one pixel per cycle while the output is not
//   stalled: each pixel makes one read of the row error memory at its input
//   transfer and at most one write when it leaves the compute stage, and the
//   extra write at a row end is parked and retired in a free write slot.
//   Reset clears the row error memory, one entry a cycle; in_stall is high
//   during that pass. Configuration writes (cfg_write / cfg_index / cfg_data)
//   go in only while the block is idle; the user must keep to this, as the
//   block does not enforce it. A stalled output holds its result and one more
//   pixel in the compute stage; in_stall then rises until the output is taken.
`include "assert_macros.svh"
module error_diffusion_halftone #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [edh_pkg::PIX_W-1:0]     pixel_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [edh_pkg::PIX_W-1:0]     pixel_out,
  output logic                          row_end,
  output logic                          image_end,
  input  logic                          cfg_write,
  input  logic [edh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [edh_pkg::DIM_W-1:0]     cfg_data
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int MW    = $clog2(MAX_WIDTH + 1);
  localparam int CMPW  = (MW > edh_pkg::DIM_W) ? MW : edh_pkg::DIM_W;

  // Configuration registers
  logic [edh_pkg::PIX_W-1:0] threshold_level;
  logic [edh_pkg::DIM_W-1:0] image_width;
  logic [edh_pkg::DIM_W-1:0] image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_level <= edh_pkg::THRESHOLD_RST;
      image_width     <= edh_pkg::WIDTH_RST;
      image_height    <= edh_pkg::HEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        edh_pkg::REG_THRESHOLD: threshold_level <= cfg_data[edh_pkg::PIX_W-1:0];
        edh_pkg::REG_WIDTH:     image_width     <= cfg_data;
        edh_pkg::REG_HEIGHT:    image_height    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective image size
  logic [CMPW-1:0]           w_ext, w_eff;
  logic [edh_pkg::DIM_W-1:0] h_eff;

  always_comb begin
    w_ext = CMPW'(image_width);
    if (w_ext < CMPW'(edh_pkg::DIM_MIN)) w_eff = CMPW'(edh_pkg::DIM_MIN);
    else if (w_ext > CMPW'(MAX_WIDTH)) w_eff = CMPW'(MAX_WIDTH);
    else w_eff = w_ext;
    if (image_height < edh_pkg::DIM_MIN) h_eff = edh_pkg::DIM_MIN;
    else if (image_height > edh_pkg::HEIGHT_LIMIT) h_eff = edh_pkg::HEIGHT_LIMIT;
    else h_eff = image_height;
  end

  // Clearing pass
  logic          clr_busy;
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      if (clr_addr == AW'(MAX_WIDTH - 1)) clr_busy <= 1'b0;
      else clr_addr <= clr_addr + AW'(1);
    end
  end

  // Handshake
  logic s1_valid, s1_adv, out_free, accept;

  assign out_free = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && out_free;
  assign in_stall = clr_busy || (s1_valid && !out_free);
  assign accept   = in_valid && !in_stall;

  // Raster position of the next input
  logic [AW-1:0]             col;
  logic [edh_pkg::ROW_W-1:0] row;
  edh_pkg::pos_t             pos_in;

  always_comb begin
    pos_in.last_col = (CMPW'(col) + CMPW'(1)) >= w_eff;
    pos_in.last_row = (edh_pkg::DIM_W'(row) + edh_pkg::DIM_W'(1)) >= h_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (pos_in.last_col) begin
        col <= '0;
        row <= pos_in.last_row ? '0 : row + edh_pkg::ROW_W'(1);
      end else begin
        col <= col + AW'(1);
      end
    end
  end

  // Compute stage registers
  logic [edh_pkg::PIX_W-1:0] s1_pixel;
  logic [AW-1:0]             s1_col;
  edh_pkg::pos_t             s1_pos;
  logic                      fwd_sel;
  edh_pkg::err_val_t         fwd_data;
  logic [edh_pkg::ERR_W-1:0] mem_q;
  edh_pkg::err_val_t         row_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // Write-back signals
  logic                      prim_we;
  logic [AW-1:0]             prim_addr;
  edh_pkg::err_val_t         prim_data;
  logic                      hold_set;
  logic                      hold_valid;
  logic [AW-1:0]             hold_addr;
  edh_pkg::err_val_t         hold_data;
  logic                      fwd_prim, fwd_hold;

  assign fwd_prim = prim_we && (prim_addr == col);
  assign fwd_hold = hold_valid && (hold_addr == col);

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel <= pixel_in;
      s1_col   <= col;
      s1_pos   <= pos_in;
      fwd_sel  <= fwd_prim || fwd_hold;
      fwd_data <= fwd_prim ? prim_data : hold_data;
    end
  end

  assign row_err = fwd_sel ? fwd_data : $signed(mem_q);

  // Pixel arithmetic
  edh_pkg::err_state_t err_state, err_next;
  logic                white;
  edh_pkg::err_val_t   left_data, below_data;

  edh_core u_core (
    .pixel      (s1_pixel),
    .row_err    (row_err),
    .err_in     (err_state),
    .threshold  (threshold_level),
    .pos        (s1_pos),
    .white      (white),
    .err_next   (err_next),
    .left_data  (left_data),
    .below_data (below_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      err_state <= '0;
    end else if (s1_adv) begin
      err_state <= err_next;
    end
  end

  // Primary write: down-left share, or a clear on the bottom row
  always_comb begin
    prim_we   = s1_adv && (s1_pos.last_row || (s1_col != '0));
    prim_addr = s1_pos.last_row ? s1_col : s1_col - AW'(1);
    prim_data = s1_pos.last_row ? edh_pkg::ERR_ZERO : left_data;
    hold_set  = s1_adv && !s1_pos.last_row && s1_pos.last_col;
  end

  // Parked row-end write, retired in the next free write slot
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (hold_set) begin
      hold_valid <= 1'b1;
    end else if (prim_we && (prim_addr == hold_addr)) begin
      hold_valid <= 1'b0;
    end else if (!prim_we) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_set) begin
      hold_addr <= s1_col;
      hold_data <= below_data;
    end
  end

  // Row error memory
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [edh_pkg::ERR_W-1:0] mem_wdata;

  always_comb begin
    mem_we = clr_busy || prim_we || hold_valid;
    if (clr_busy) begin
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (prim_we) begin
      mem_waddr = prim_addr;
      mem_wdata = prim_data;
    end else begin
      mem_waddr = hold_addr;
      mem_wdata = hold_data;
    end
  end

  edh_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW),
    .DW    (edh_pkg::ERR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (col),
    .rdata (mem_q)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      pixel_out <= white ? edh_pkg::PIX_WHITE : edh_pkg::PIX_BLACK;
      row_end   <= s1_pos.last_col;
      image_end <= s1_pos.last_col && s1_pos.last_row;
    end
  end

  // Checks
  `ASSERT_CLK(a_hold_free, hold_set |-> !hold_valid, "row-end write parked over a pending one")
  `ASSERT_ALWAYS(a_no_accept_clr, accept |-> !clr_busy, "pixel transfer during memory clear")
  `ASSERT_CLK(a_pix_binary, out_valid |-> (pixel_out == 8'd0 || pixel_out == 8'd255), "non-binary pixel")
  `ASSERT_CLK(a_image_row, (out_valid && image_end) |-> row_end, "image end without row end")

endmodule

[sim/testbench.sv]
// testbench.sv: self-checking bench for the error_diffusion_halftone block.
// Needs edh_pkg and the halftoner RTL; a built-in predictor checks every output pixel.

module testbench;

  localparam int MAX_W = 1024;
  localparam int RANDOM_ITEMS = 1880;
  localparam int QUIET_FROM = 1600;
  // index past the last register; the block must ignore it
  localparam logic [edh_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum int {STYLE_NOISE, STYLE_FLAT, STYLE_EDGE} level_style_t;

  // One expected output transfer
  typedef struct packed {
    logic [edh_pkg::PIX_W-1:0] level;
    logic                      row_last;
    logic                      image_last;
  } halftone_t;

  // Clamp to the 10-bit signed working range
  function automatic int clip_err(input int v);
    if (v > 511) return 511;
    if (v < -512) return -512;
    return v;
  endfunction

  // k sixteenths of e, truncated toward zero
  function automatic int portion(input int e, input int k);
    if (e < 0) return -(((-e) * k) >> 4);
    return (e * k) >> 4;
  endfunction

  // Halftone predictor and store of expected output pixels
  class halftone_predictor;
    logic [edh_pkg::PIX_W-1:0] thresh;
    logic [edh_pkg::DIM_W-1:0] width_reg;
    logic [edh_pkg::DIM_W-1:0] height_reg;
    edh_pkg::err_val_t         row_err[MAX_W];
    edh_pkg::err_val_t         carry;
    edh_pkg::err_val_t         pend_prev;
    edh_pkg::err_val_t         pend_cur;
    int                        col;
    int                        row;
    halftone_t                 expected_dots[$];
    int                        mismatches;
    int                        dots_checked;
    int                        rows_seen;
    int                        images_seen;

    function new();
      thresh = edh_pkg::THRESHOLD_RST;
      width_reg = edh_pkg::WIDTH_RST;
      height_reg = edh_pkg::HEIGHT_RST;
      foreach (row_err[i]) row_err[i] = edh_pkg::ERR_ZERO;
      carry = edh_pkg::ERR_ZERO;
      pend_prev = edh_pkg::ERR_ZERO;
      pend_cur = edh_pkg::ERR_ZERO;
      col = 0;
      row = 0;
      mismatches = 0;
      dots_checked = 0;
      rows_seen = 0;
      images_seen = 0;
    endfunction

    function void set_reg(input logic [edh_pkg::CFG_IDX_W-1:0] idx,
                          input logic [edh_pkg::DIM_W-1:0] data);
      case (idx)
        edh_pkg::REG_THRESHOLD: thresh = data[edh_pkg::PIX_W-1:0];
        edh_pkg::REG_WIDTH:     width_reg = data;
        edh_pkg::REG_HEIGHT:    height_reg = data;
        default: ;
      endcase
    endfunction

    // Advance the raster state by one accepted input pixel
    function void note_pixel(input logic [edh_pkg::PIX_W-1:0] p);
      int        w;
      int        h;
      int        c;
      int        v;
      int        e;
      int        below;
      bit        last_col;
      bit        last_row;
      halftone_t r;
      w = int'(width_reg);
      if (w < int'(edh_pkg::DIM_MIN)) w = int'(edh_pkg::DIM_MIN);
      else if (w > MAX_W) w = MAX_W;
      h = int'(height_reg);
      if (h < int'(edh_pkg::DIM_MIN)) h = int'(edh_pkg::DIM_MIN);
      else if (h > int'(edh_pkg::HEIGHT_LIMIT)) h = int'(edh_pkg::HEIGHT_LIMIT);
      c = col % MAX_W;
      last_col = (col + 1 >= w);
      last_row = (row + 1 >= h);

      v = clip_err(int'(p) + int'(carry) + int'(row_err[c]));
      if (v <= int'(thresh)) begin
        r.level = edh_pkg::PIX_BLACK;
        e = v;
      end else begin
        r.level = edh_pkg::PIX_WHITE;
        e = v - 255;
      end

      // error for the next row; the bottom row passes none down
      if (last_row) begin
        row_err[c] = edh_pkg::ERR_ZERO;
        pend_prev = edh_pkg::ERR_ZERO;
        pend_cur = edh_pkg::ERR_ZERO;
      end else begin
        below = clip_err(int'(pend_cur) + portion(e, int'(edh_pkg::K_DOWN)));
        if (c > 0)
          row_err[c-1] = edh_pkg::err_val_t'(
            clip_err(int'(pend_prev) + portion(e, int'(edh_pkg::K_DOWN_LEFT))));
        if (last_col) begin
          row_err[c] = edh_pkg::err_val_t'(below);
          pend_prev = edh_pkg::ERR_ZERO;
          pend_cur = edh_pkg::ERR_ZERO;
        end else begin
          pend_prev = edh_pkg::err_val_t'(below);
          pend_cur = edh_pkg::err_val_t'(portion(e, int'(edh_pkg::K_DOWN_RIGHT)));
        end
      end

      // position and the carry to the right
      if (last_col) begin
        carry = edh_pkg::ERR_ZERO;
        col = 0;
        row = last_row ? 0 : row + 1;
        rows_seen++;
        if (last_row) images_seen++;
      end else begin
        carry = edh_pkg::err_val_t'(clip_err(portion(e, int'(edh_pkg::K_RIGHT))));
        col++;
      end

      r.row_last = last_col;
      r.image_last = last_col && last_row;
      expected_dots.push_back(r);
    endfunction

    function void flag(input string what, input logic [edh_pkg::PIX_W-1:0] want,
                       input logic [edh_pkg::PIX_W-1:0] got);
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endfunction

    // Compare one output transfer with the oldest expectation
    function void check_dot(input logic [edh_pkg::PIX_W-1:0] level, input logic row_last,
                            input logic image_last);
      halftone_t want;
      if (expected_dots.size() == 0) begin
        mismatches++;
        $display("%0t: output with nothing expected, expected none, actual %0d", $time, level);
        return;
      end
      want = expected_dots.pop_front();
      dots_checked++;
      if (level !== want.level) flag("pixel_out", want.level, level);
      if (row_last !== want.row_last)
        flag("row_end", edh_pkg::PIX_W'(want.row_last), edh_pkg::PIX_W'(row_last));
      if (image_last !== want.image_last)
        flag("image_end", edh_pkg::PIX_W'(want.image_last), edh_pkg::PIX_W'(image_last));
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  logic [edh_pkg::PIX_W-1:0]     pixel_in;
  logic                          out_valid;
  logic                          out_stall;
  logic [edh_pkg::PIX_W-1:0]     pixel_out;
  logic                          row_end;
  logic                          image_end;
  logic                          cfg_write;
  logic [edh_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [edh_pkg::DIM_W-1:0]     cfg_data;

  halftone_predictor dots = new();
  bit                quiet_tail;
  int                sizes_used;
  int                sent_random;
  int                phase_no;

  error_diffusion_halftone #(.MAX_WIDTH(MAX_W)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .pixel_in(pixel_in),
    .out_valid(out_valid), .out_stall(out_stall), .pixel_out(pixel_out),
    .row_end(row_end), .image_end(image_end),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

  // Output side: check each transfer, stall in random bursts
  initial begin
    int hold;
    hold = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && !out_stall)
        dots.check_dot(pixel_out, row_end, image_end);
      if (hold > 0) hold--;
      else if (!quiet_tail && $urandom_range(0, 5) == 0) hold = $urandom_range(1, 5);
      out_stall <= (hold > 0);
    end
  end

  // Present one pixel and hold it until the transfer
  task automatic send_pixel(input logic [edh_pkg::PIX_W-1:0] p);
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_in <= p;
    do @(posedge clk); while (in_stall);
    dots.note_pixel(p);
  endtask

  // Stop sending and wait for every expected pixel, plus the pipeline depth
  task automatic drain_outputs();
    in_valid <= 1'b0;
    while (dots.expected_dots.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write all registers once the block is idle
  task automatic program_regs(input logic [edh_pkg::PIX_W-1:0] thr,
                              input logic [edh_pkg::DIM_W-1:0] wid,
                              input logic [edh_pkg::DIM_W-1:0] hgt, input bit poke_unused);
    logic [edh_pkg::CFG_IDX_W-1:0] idx_q[$];
    logic [edh_pkg::DIM_W-1:0]     val_q[$];
    int                            i;
    drain_outputs();
    idx_q.push_back(edh_pkg::REG_THRESHOLD);
    val_q.push_back({3'b000, thr});
    if (poke_unused) begin
      idx_q.push_back(REG_UNUSED);
      val_q.push_back(11'h7ff);
    end
    idx_q.push_back(edh_pkg::REG_WIDTH);
    val_q.push_back(wid);
    idx_q.push_back(edh_pkg::REG_HEIGHT);
    val_q.push_back(hgt);
    cfg_write <= 1'b1;
    for (i = 0; i < idx_q.size(); i++) begin
      cfg_index <= idx_q[i];
      cfg_data <= val_q[i];
      @(posedge clk);
      dots.set_reg(idx_q[i], val_q[i]);
    end
    cfg_write <= 1'b0;
    sizes_used++;
  endtask

  function automatic logic [edh_pkg::PIX_W-1:0] pick_level(
      input level_style_t style, input logic [edh_pkg::PIX_W-1:0] base,
      input logic [edh_pkg::PIX_W-1:0] thr);
    int n;
    case (style)
      STYLE_FLAT: n = int'(base) + int'($urandom_range(0, 6)) - 3;
      STYLE_EDGE: n = int'(thr) + int'($urandom_range(0, 8)) - 4;
      default: begin
        n = int'($urandom_range(0, 7));
        if (n == 0) n = 0;
        else if (n == 1) n = 255;
        else n = int'($urandom_range(0, 255));
      end
    endcase
    if (n < 0) n = 0;
    if (n > 255) n = 255;
    return edh_pkg::PIX_W'(n);
  endfunction

  // One random setting and a run of pixels in a random texture
  task automatic run_phase(input logic [edh_pkg::PIX_W-1:0] thr,
                           input logic [edh_pkg::DIM_W-1:0] wid,
                           input logic [edh_pkg::DIM_W-1:0] hgt, input int count,
                           input bit poke_unused);
    level_style_t              style;
    logic [edh_pkg::PIX_W-1:0] base;
    int                        i;
    program_regs(thr, wid, hgt, poke_unused);
    style = level_style_t'($urandom_range(0, 2));
    base = edh_pkg::PIX_W'($urandom_range(0, 255));
    for (i = 0; i < count; i++) send_pixel(pick_level(style, base, thr));
  endtask

  initial begin
    logic [edh_pkg::PIX_W-1:0] thr;
    logic [edh_pkg::DIM_W-1:0] wid;
    logic [edh_pkg::DIM_W-1:0] hgt;
    int                        we;
    int                        he;
    int                        count;
    quiet_tail = 1'b0;
    sizes_used = 1;
    sent_random = 0;
    phase_no = 0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    pixel_in <= '0;
    cfg_write <= 1'b0;
    cfg_index <= edh_pkg::REG_THRESHOLD;
    cfg_data <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings: white, black, and a level equal to the threshold
    send_pixel(edh_pkg::PIX_WHITE);
    send_pixel(edh_pkg::PIX_BLACK);
    send_pixel(8'd128);
    // shrink to 2x2 with the column counter past the new row end;
    // threshold zero, and a write to the unused index
    program_regs(8'd0, 11'd2, 11'd2, 1'b1);
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd1);
    send_pixel(8'd254);
    // sizes below the minimum act as 2x2; threshold at full scale
    program_regs(8'd255, 11'd1, 11'd0, 1'b0);
    send_pixel(8'd255);
    send_pixel(8'd255);
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd128);
    // nine pixels at 3x3 size: left and right columns, bottom row
    program_regs(edh_pkg::THRESHOLD_RST, 11'd3, 11'd3, 1'b0);
    send_pixel(8'd200);
    send_pixel(8'd60);
    send_pixel(8'd255);
    send_pixel(8'd0);
    send_pixel(8'd130);
    send_pixel(8'd90);
    send_pixel(8'd255);
    send_pixel(8'd10);
    send_pixel(8'd128);

    // random settings, mostly small images, a full-width run and a run at maximum height
    while (sent_random < RANDOM_ITEMS) begin
      if (sent_random >= QUIET_FROM) quiet_tail = 1'b1;
      case ($urandom_range(0, 5))
        0: thr = 8'd0;
        1: thr = 8'd255;
        default: thr = edh_pkg::PIX_W'($urandom_range(0, 255));
      endcase
      if (phase_no == 1) begin
        wid = $urandom_range(0, 1) ? 11'd1024 : edh_pkg::DIM_W'($urandom_range(1025, 2047));
        hgt = edh_pkg::DIM_W'($urandom_range(2, 3));
        count = 1030;
      end else if (phase_no == 3) begin
        wid = 11'd2;
        hgt = $urandom_range(0, 1) ? 11'd1024 : edh_pkg::DIM_W'($urandom_range(1025, 2047));
        count = 40;
      end else begin
        wid = ($urandom_range(0, 9) == 0) ? edh_pkg::DIM_W'($urandom_range(0, 1))
                                           : edh_pkg::DIM_W'($urandom_range(2, 12));
        hgt = ($urandom_range(0, 9) == 0) ? edh_pkg::DIM_W'($urandom_range(0, 1))
                                           : edh_pkg::DIM_W'($urandom_range(2, 6));
        we = (wid < 2) ? 2 : int'(wid);
        he = (hgt < 2) ? 2 : int'(hgt);
        count = we * he * int'($urandom_range(1, 3)) + int'($urandom_range(0, we));
      end
      run_phase(thr, wid, hgt, count, $urandom_range(0, 7) == 0);
      sent_random += count;
      phase_no++;
    end

    drain_outputs();
    repeat (10) @(posedge clk);
    $display("Checked %0d output pixels under %0d register settings (%0d rows, %0d images).",
             dots.dots_checked, sizes_used, dots.rows_seen, dots.images_seen);
    if (dots.mismatches == 0 && dots.expected_dots.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
